// ----- src/jls_pkg.sv -----
// ----------------------------------------------------------------------------
// jls_pkg
// Shared widths, command codes and register map of the Jacobi linear solver.
// ----------------------------------------------------------------------------
package jls_pkg;

   localparam int DIM       = 64;
   localparam int IDX_W     = 6;
   localparam int VAL_W     = 32;
   localparam int ACC_W     = 64;
   localparam int QUO_W     = 63;
   localparam int SIZE_W    = 7;
   localparam int ITER_W    = 16;
   localparam int TOL_W     = 31;
   localparam int CSR_AW    = 4;

   localparam logic [1:0] CMD_LOAD_A = 2'd0;
   localparam logic [1:0] CMD_LOAD_B = 2'd1;
   localparam logic [1:0] CMD_SOLVE  = 2'd2;

   localparam logic [1:0] REG_SIZE   = 2'd0;
   localparam logic [1:0] REG_MAXIT  = 2'd1;
   localparam logic [1:0] REG_TOL    = 2'd2;

   localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   // numerator clamp, +-2^46
   localparam logic signed [ACC_W-1:0] NUM_CLAMP = 64'sd70368744177664;

endpackage

// ----- src/jacobi_linear_solver.sv -----
// ----------------------------------------------------------------------------
// jacobi_linear_solver
// Jacobi iterative solver for A*x = b, signed Q16.16, memory-based sequencer.
// ----------------------------------------------------------------------------
// Load items (matrix or rhs entry) are written while idle; busy stays low.
// A solve keeps busy high over S sweeps, each with a residual pass, and the output;
//   n = matrix size; a zero-diagonal row skips the shared
//   63-step restoring divider (one quotient bit a cycle).
// Results come one per cycle, n items, strobed by rsp_valid; no back pressure.
// Synchronous active-high reset clears control state; memories are not cleared.
module jacobi_linear_solver (
   input  logic                         clock,
   input  logic                         reset,
   // command channel
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_command,
   input  logic [jls_pkg::IDX_W-1:0]    req_row_index,
   input  logic [jls_pkg::IDX_W-1:0]    req_col_index,
   input  logic signed [jls_pkg::VAL_W-1:0] req_element_value,
   // result channel
   output logic                         rsp_valid,
   output logic [jls_pkg::IDX_W-1:0]    rsp_solution_index,
   output logic signed [jls_pkg::VAL_W-1:0] rsp_solution_value,
   output logic                         rsp_converged,
   output logic [jls_pkg::ITER_W-1:0]   rsp_iterations_done,
   output logic                         rsp_divide_fault,
   output logic                         rsp_last,
   // configuration port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [jls_pkg::CSR_AW-1:0]   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   // sequencer states
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_INIT      = 4'd1;
   localparam logic [3:0] ST_ROW_ISSUE = 4'd2;
   localparam logic [3:0] ST_ROW_WAIT  = 4'd3;
   localparam logic [3:0] ST_SW_NUM    = 4'd4;
   localparam logic [3:0] ST_DIV_INIT  = 4'd5;
   localparam logic [3:0] ST_DIV_RUN   = 4'd6;
   localparam logic [3:0] ST_DIV_DONE  = 4'd7;
   localparam logic [3:0] ST_RES_ERR   = 4'd8;
   localparam logic [3:0] ST_RES_ABS   = 4'd9;
   localparam logic [3:0] ST_RES_SQ    = 4'd10;
   localparam logic [3:0] ST_RES_ADD   = 4'd11;
   localparam logic [3:0] ST_CHECK     = 4'd12;
   localparam logic [3:0] ST_OUT_ISSUE = 4'd13;
   localparam logic [3:0] ST_OUT_DRAIN = 4'd14;

   localparam int XA_W = jls_pkg::IDX_W + 1;   // two banks of x

   // ---------------------------------------------------------------------
   // Memories: A (4096), b (64), x ping-pong (2 x 64)
   // ---------------------------------------------------------------------
   logic [jls_pkg::VAL_W-1:0] a_mem [jls_pkg::DIM*jls_pkg::DIM];
   logic [jls_pkg::VAL_W-1:0] b_mem [jls_pkg::DIM];
   logic [jls_pkg::VAL_W-1:0] x_mem [2*jls_pkg::DIM];

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [jls_pkg::SIZE_W-1:0] size_ff;
   logic [jls_pkg::ITER_W-1:0] maxit_ff;
   logic [jls_pkg::TOL_W-1:0]  tol_ff;
   logic                       csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= jls_pkg::SIZE_W'(64);
         maxit_ff <= jls_pkg::ITER_W'(100);
         tol_ff   <= jls_pkg::TOL_W'(66);
      end else if (csr_wr) begin
         unique case (paddr[3:2])
            jls_pkg::REG_SIZE:  size_ff  <= pwdata[jls_pkg::SIZE_W-1:0];
            jls_pkg::REG_MAXIT: maxit_ff <= pwdata[jls_pkg::ITER_W-1:0];
            jls_pkg::REG_TOL:   tol_ff   <= pwdata[jls_pkg::TOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         jls_pkg::REG_SIZE:  prdata = {25'd0, size_ff};
         jls_pkg::REG_MAXIT: prdata = {16'd0, maxit_ff};
         jls_pkg::REG_TOL:   prdata = {1'b0, tol_ff};
         default:            prdata = 32'd0;
      endcase
   end

   // last index in use: size 0 acts as 1, above 64 acts as 64
   logic [jls_pkg::IDX_W-1:0] n_m1;
   always_comb begin
      priority if (size_ff == '0)
         n_m1 = '0;
      else if (size_ff > jls_pkg::SIZE_W'(jls_pkg::DIM))
         n_m1 = jls_pkg::IDX_W'(jls_pkg::DIM - 1);
      else
         n_m1 = 6'(size_ff - 7'd1);
   end

   // ---------------------------------------------------------------------
   // Sequencer registers
   // ---------------------------------------------------------------------
   logic [3:0]                 state_ff, state_in;
   logic [jls_pkg::IDX_W-1:0]  row_ff, row_in;
   logic [jls_pkg::IDX_W-1:0]  col_ff, col_in;
   logic [jls_pkg::IDX_W-1:0]  k_ff, k_in;
   logic                       res_mode_ff, res_mode_in;  // residual pass
   logic                       cur_ff, cur_in;            // bank holding x
   logic                       xzero_ff, xzero_in;        // x still all zero
   logic [jls_pkg::ITER_W-1:0] sweep_ff, sweep_in;
   logic                       fault_ff, fault_in;
   logic                       conv_ff, conv_in;
   logic                       fail_ff, fail_in;
   logic [61:0]                lim_ff, lim_in;
   logic [jls_pkg::ACC_W-1:0]  sum_ff, sum_in;
   logic signed [jls_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [jls_pkg::ACC_W-1:0] num_ff, num_in;      // also residual e
   logic [jls_pkg::ACC_W-1:0]  mag_ff, mag_in;
   logic [jls_pkg::ACC_W-1:0]  sq_ff, sq_in;
   logic signed [jls_pkg::VAL_W-1:0] diag_ff, diag_in;
   // divider
   logic [jls_pkg::QUO_W-1:0]  dvd_ff, dvd_in;   // dividend, becomes quotient
   logic [jls_pkg::VAL_W-1:0]  rem_ff, rem_in;
   logic [jls_pkg::VAL_W-1:0]  den_ff, den_in;
   logic                       neg_ff, neg_in;
   logic [5:0]                 dcnt_ff, dcnt_in;
   // read pipeline
   logic                       iss_v, iss_diag, iss_last;
   logic                       s1_v_ff, s1_diag_ff, s1_last_ff;
   logic                       s2_v_ff, s2_diag_ff, s2_last_ff;
   logic signed [jls_pkg::VAL_W-1:0] a_rd_ff;
   logic signed [jls_pkg::VAL_W-1:0] x_rd_ff;
   logic signed [jls_pkg::VAL_W-1:0] b_rd_ff;
   logic signed [jls_pkg::ACC_W-1:0] prod_ff;
   logic signed [jls_pkg::VAL_W-1:0] x_op;
   // output strobe stage
   logic                       out_iss;
   logic                       o_v_ff;
   logic [jls_pkg::IDX_W-1:0]  o_idx_ff;
   logic                       o_last_ff;

   // memory ports
   logic [XA_W-1:0]            x_raddr;
   logic                       x_we;
   logic [jls_pkg::VAL_W-1:0]  x_wdata;
   logic                       acc_take;

   logic                       accept;
   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (accept && req_command == jls_pkg::CMD_LOAD_A)
         a_mem[{req_row_index, req_col_index}] <= req_element_value;
      a_rd_ff <= a_mem[{row_ff, col_ff}];
   end

   always_ff @(posedge clock) begin
      if (accept && req_command == jls_pkg::CMD_LOAD_B)
         b_mem[req_row_index] <= req_element_value;
      b_rd_ff <= b_mem[row_ff];
   end

   always_ff @(posedge clock) begin
      if (x_we)
         x_mem[{!cur_ff, row_ff}] <= x_wdata;
      x_rd_ff <= x_mem[x_raddr];
   end

   assign x_raddr = (state_ff == ST_OUT_ISSUE) ? {cur_ff, k_ff} : {cur_ff, col_ff};
   assign x_op    = xzero_ff ? '0 : x_rd_ff;

   assign iss_v    = (state_ff == ST_ROW_ISSUE);
   assign iss_diag = (col_ff == row_ff);
   assign iss_last = (col_ff == n_m1);
   assign out_iss  = (state_ff == ST_OUT_ISSUE);

   // product stage; diagonal skipped in a sweep, kept in the residual
   assign acc_take = s2_v_ff && !(s2_diag_ff && !res_mode_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         o_v_ff  <= 1'b0;
      end else begin
         s1_v_ff <= iss_v;
         s2_v_ff <= s1_v_ff;
         o_v_ff  <= out_iss;
      end
      s1_diag_ff <= iss_diag;
      s1_last_ff <= iss_last;
      s2_diag_ff <= s1_diag_ff;
      s2_last_ff <= s1_last_ff;
      prod_ff    <= 64'(a_rd_ff) * 64'(x_op);
      o_idx_ff   <= k_ff;
      o_last_ff  <= (k_ff == n_m1);
   end

   // divider step and saturation
   logic [jls_pkg::VAL_W:0]    div_sh, div_try;
   logic [jls_pkg::VAL_W-1:0]  sat_val;
   logic [jls_pkg::QUO_W-1:0]  q_neg;
   logic signed [jls_pkg::ACC_W-1:0] num_cl;
   logic [jls_pkg::ACC_W-1:0]  num_mag;
   logic [jls_pkg::ACC_W-1:0]  rhs_ext;

   assign div_sh  = {rem_ff, dvd_ff[jls_pkg::QUO_W-1]};
   assign div_try = div_sh - {1'b0, den_ff};
   assign q_neg   = -dvd_ff;
   assign rhs_ext = {{32{b_rd_ff[31]}}, b_rd_ff};

   always_comb begin
      priority if (!neg_ff && dvd_ff > 63'h7FFF_FFFF)
         sat_val = jls_pkg::VAL_MAX;
      else if (neg_ff && dvd_ff > 63'h8000_0000)
         sat_val = jls_pkg::VAL_MIN;
      else if (neg_ff)
         sat_val = q_neg[jls_pkg::VAL_W-1:0];
      else
         sat_val = dvd_ff[jls_pkg::VAL_W-1:0];
   end

   always_comb begin
      priority if (num_ff > jls_pkg::NUM_CLAMP)
         num_cl = jls_pkg::NUM_CLAMP;
      else if (num_ff < -jls_pkg::NUM_CLAMP)
         num_cl = -jls_pkg::NUM_CLAMP;
      else
         num_cl = num_ff;
      num_mag = num_cl[63] ? 64'(-num_cl) : 64'(num_cl);
   end

   assign x_we    = (state_ff == ST_DIV_DONE);
   assign x_wdata = sat_val;

   // ---------------------------------------------------------------------
   // Next-state logic
   // ---------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      k_in        = k_ff;
      res_mode_in = res_mode_ff;
      cur_in      = cur_ff;
      xzero_in    = xzero_ff;
      sweep_in    = sweep_ff;
      fault_in    = fault_ff;
      conv_in     = conv_ff;
      fail_in     = fail_ff;
      lim_in      = lim_ff;
      sum_in      = sum_ff;
      acc_in      = acc_ff;
      num_in      = num_ff;
      mag_in      = mag_ff;
      sq_in       = sq_ff;
      diag_in     = diag_ff;
      dvd_in      = dvd_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      neg_in      = neg_ff;
      dcnt_in     = dcnt_ff;

      if (s1_v_ff && s1_diag_ff)
         diag_in = a_rd_ff;
      if (acc_take)
         acc_in = acc_ff + (prod_ff >>> 16);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == jls_pkg::CMD_SOLVE)
               state_in = ST_INIT;
         end
         ST_INIT: begin
            sweep_in = '0;
            fault_in = 1'b0;
            xzero_in = 1'b1;
            conv_in  = 1'b0;
            lim_in   = 62'(tol_ff) * 62'(tol_ff);
            row_in   = '0;
            col_in   = '0;
            k_in     = '0;
            acc_in   = '0;
            res_mode_in = 1'b0;
            state_in = (maxit_ff == '0) ? ST_OUT_ISSUE : ST_ROW_ISSUE;
         end
         ST_ROW_ISSUE: begin
            col_in = col_ff + 6'd1;
            if (iss_last)
               state_in = ST_ROW_WAIT;
         end
         ST_ROW_WAIT: begin
            if (s2_v_ff && s2_last_ff)
               state_in = res_mode_ff ? ST_RES_ERR : ST_SW_NUM;
         end
         ST_SW_NUM: begin
            num_in   = rhs_ext - acc_ff;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            neg_in  = num_ff[63] ^ diag_ff[31];
            rem_in  = '0;
            dcnt_in = 6'(jls_pkg::QUO_W - 1);
            den_in  = diag_ff[31] ? 32'(-diag_ff) : 32'(diag_ff);
            if (diag_ff == '0) begin
               // zero diagonal: force a saturated or zero quotient
               fault_in = 1'b1;
               neg_in   = num_ff[63];
               dvd_in   = (num_ff == '0) ? '0 : '1;
               state_in = ST_DIV_DONE;
            end else begin
               dvd_in   = {num_mag[46:0], 16'd0};
               state_in = ST_DIV_RUN;
            end
         end
         ST_DIV_RUN: begin
            if (!div_try[jls_pkg::VAL_W]) begin
               rem_in = div_try[jls_pkg::VAL_W-1:0];
               dvd_in = {dvd_ff[jls_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rem_in = div_sh[jls_pkg::VAL_W-1:0];
               dvd_in = {dvd_ff[jls_pkg::QUO_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 6'd1;
            if (dcnt_ff == '0)
               state_in = ST_DIV_DONE;
         end
         ST_DIV_DONE: begin
            col_in   = '0;
            acc_in   = '0;
            state_in = ST_ROW_ISSUE;
            if (row_ff == n_m1) begin
               // sweep finished: new x becomes current, residual pass next
               cur_in      = !cur_ff;
               xzero_in    = 1'b0;
               sweep_in    = sweep_ff + 16'd1;
               res_mode_in = 1'b1;
               row_in      = '0;
               sum_in      = '0;
               fail_in     = 1'b0;
            end else begin
               row_in = row_ff + 6'd1;
            end
         end
         ST_RES_ERR: begin
            num_in   = rhs_ext - acc_ff;
            state_in = ST_RES_ABS;
         end
         ST_RES_ABS: begin
            mag_in   = num_ff[63] ? 64'(-num_ff) : 64'(num_ff);
            state_in = ST_RES_SQ;
         end
         ST_RES_SQ: begin
            if (mag_ff[63:32] != '0)
               fail_in = 1'b1;
            sq_in    = 64'(mag_ff[31:0]) * 64'(mag_ff[31:0]);
            state_in = ST_RES_ADD;
         end
         ST_RES_ADD: begin
            if ({1'b0, sum_ff} + {1'b0, sq_ff} > 65'h0_FFFF_FFFF_FFFF_FFFF)
               fail_in = 1'b1;
            else
               sum_in = sum_ff + sq_ff;
            col_in = '0;
            acc_in = '0;
            if (row_ff == n_m1) begin
               state_in = ST_CHECK;
            end else begin
               row_in   = row_ff + 6'd1;
               state_in = ST_ROW_ISSUE;
            end
         end
         ST_CHECK: begin
            conv_in     = !fail_ff && (sum_ff <= {2'b00, lim_ff});
            row_in      = '0;
            col_in      = '0;
            acc_in      = '0;
            k_in        = '0;
            res_mode_in = 1'b0;
            if ((!fail_ff && (sum_ff <= {2'b00, lim_ff})) || sweep_ff == maxit_ff)
               state_in = ST_OUT_ISSUE;
            else
               state_in = ST_ROW_ISSUE;
         end
         ST_OUT_ISSUE: begin
            k_in = k_ff + 6'd1;
            if (k_ff == n_m1)
               state_in = ST_OUT_DRAIN;
         end
         ST_OUT_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sweep_ff <= '0;
         fault_ff <= 1'b0;
         conv_ff  <= 1'b0;
         xzero_ff <= 1'b1;
         cur_ff   <= 1'b0;
         res_mode_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         fault_ff <= fault_in;
         conv_ff  <= conv_in;
         xzero_ff <= xzero_in;
         cur_ff   <= cur_in;
         res_mode_ff <= res_mode_in;
      end
      row_ff  <= row_in;
      col_ff  <= col_in;
      k_ff    <= k_in;
      fail_ff <= fail_in;
      lim_ff  <= lim_in;
      sum_ff  <= sum_in;
      acc_ff  <= acc_in;
      num_ff  <= num_in;
      mag_ff  <= mag_in;
      sq_ff   <= sq_in;
      diag_ff <= diag_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      dcnt_ff <= dcnt_in;
   end

   // ---------------------------------------------------------------------
   // Result ports; x reads as zero when no sweep ran
   // ---------------------------------------------------------------------
   assign rsp_valid           = o_v_ff;
   assign rsp_solution_index  = o_idx_ff;
   assign rsp_solution_value  = x_op;
   assign rsp_converged       = conv_ff;
   assign rsp_iterations_done = sweep_ff;
   assign rsp_divide_fault    = fault_ff;
   assign rsp_last            = o_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("result after last item");

   a_solve_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == jls_pkg::CMD_SOLVE) |=> busy)
      else $error("solve not started");

   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_RUN) |-> (den_ff != '0))
      else $error("divider running on zero divisor");

endmodule
